@@ src/dq_pkg.sv @@
// Shared types and constants for the double-ended queue.
package dq_pkg;

  localparam int DEPTH_DEF      = 16;
  localparam int DATA_WIDTH_DEF = 32;

  localparam int OPCODE_W = 2;
  localparam int VALUE_W  = 32;
  localparam int COUNT_W  = 5;
  localparam int STATUS_W = 2;

  typedef enum logic [OPCODE_W-1:0] {
    OP_PUSH_FRONT = 2'd0,
    OP_PUSH_BACK  = 2'd1,
    OP_POP_FRONT  = 2'd2,
    OP_POP_BACK   = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

endpackage

@@ src/dq_ram.sv @@
// Generic simple dual-port RAM, one write port, one registered read port.
module dq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ src/double_ended_queue.sv @@
// Double-ended queue on a ring buffer: top level with pointer and count control.
// An accepted beat is registered in the s1 stage, then in the output register; the slot
// read of a pop goes through the RAM's registered read port on the accepting edge.
// No new beat is taken while one is in s1 or an untaken result waits in the output register.
// Reset clears the front and back indices, the count and all valid flags;
// slot contents are not cleared and are only read after a push wrote them.
module double_ended_queue
  import dq_pkg::*;
#(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [OPCODE_W-1:0] opcode,
  input  logic [VALUE_W-1:0]  value,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [VALUE_W-1:0]  popped_value,
  output logic [COUNT_W-1:0]  count,
  output logic [STATUS_W-1:0] status
);

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  logic [IDX_W-1:0] front_index, front_index_next;
  logic [IDX_W-1:0] back_index, back_index_next;
  logic [CNT_W-1:0] elem_count, elem_count_next;

  // Stage between RAM access and result register
  logic                s1_valid;
  logic                s1_pop_ok;
  logic [CNT_W-1:0]    s1_count;
  status_t             s1_status;

  logic                accept;
  op_t                 op;
  logic                ram_we, ram_re;
  logic [IDX_W-1:0]    ram_waddr, ram_raddr;
  logic [DATA_WIDTH-1:0] ram_rdata;
  status_t             status_next;

  logic [IDX_W-1:0] front_inc, front_dec, back_inc, back_dec;

  assign front_inc = (front_index == IDX_LAST) ? '0 : front_index + 1'b1;
  assign front_dec = (front_index == '0) ? IDX_LAST : front_index - 1'b1;
  assign back_inc  = (back_index == IDX_LAST) ? '0 : back_index + 1'b1;
  assign back_dec  = (back_index == '0) ? IDX_LAST : back_index - 1'b1;

  // Ready when s1 is empty and the output register is free next cycle: empty or being taken now.
  assign in_ready = !s1_valid && (!out_valid || out_ready);
  assign accept   = in_valid && in_ready;
  assign op       = op_t'(opcode);

  always_comb begin
    front_index_next = front_index;
    back_index_next  = back_index;
    elem_count_next  = elem_count;
    status_next      = ST_OK;
    ram_we           = 1'b0;
    ram_re           = 1'b0;
    ram_waddr        = back_index;
    ram_raddr        = front_index;
    unique case (op)
      OP_PUSH_FRONT: begin
        if (elem_count == CNT_FULL) begin
          status_next = ST_FULL;
        end else begin
          front_index_next = front_dec;
          ram_waddr        = front_dec;
          ram_we           = accept;
          elem_count_next  = elem_count + 1'b1;
        end
      end
      OP_PUSH_BACK: begin
        if (elem_count == CNT_FULL) begin
          status_next = ST_FULL;
        end else begin
          back_index_next = back_inc;
          ram_waddr       = back_index;
          ram_we          = accept;
          elem_count_next = elem_count + 1'b1;
        end
      end
      OP_POP_FRONT: begin
        if (elem_count == '0) begin
          status_next = ST_EMPTY;
        end else begin
          front_index_next = front_inc;
          ram_raddr        = front_index;
          ram_re           = accept;
          elem_count_next  = elem_count - 1'b1;
        end
      end
      OP_POP_BACK: begin
        if (elem_count == '0) begin
          status_next = ST_EMPTY;
        end else begin
          back_index_next = back_dec;
          ram_raddr       = back_dec;
          ram_re          = accept;
          elem_count_next = elem_count - 1'b1;
        end
      end
      default: begin
        status_next = ST_OK;
      end
    endcase
  end

  dq_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (DATA_WIDTH'(value)),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      front_index <= '0;
      back_index  <= '0;
      elem_count  <= '0;
      s1_valid    <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (accept) begin
        front_index <= front_index_next;
        back_index  <= back_index_next;
        elem_count  <= elem_count_next;
      end
      s1_valid <= accept;
      if (s1_valid) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pop_ok <= ram_re;
      s1_count  <= elem_count_next;
      s1_status <= status_next;
    end
    if (s1_valid) begin
      popped_value <= s1_pop_ok ? VALUE_W'(ram_rdata) : '0;
      count        <= COUNT_W'(s1_count);
      status       <= s1_status;
    end
  end

endmodule
